// File: src/kwm_pkg.sv
// ----------------------------------------------------------------------------
// K-way merge package
// Shared widths, default parameter values and input mode codes of the merge.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int DEF_MAX_RUNS   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int RUN_W       = 4;
    localparam int RUN_COUNT_W = 5;

    localparam logic MODE_PRIME = 1'b0;
    localparam logic MODE_REPLY = 1'b1;

endpackage

// File: src/k_way_merge_of_sorted_runs.sv
// ----------------------------------------------------------------------------
// K-way merge of sorted runs
// Merges ascending runs into one ascending stream through a min-heap of run
// heads, kept in a memory with one read and one write port and walked by a
// small sequencer.
// A priming push sifts the new head up towards the root; a pop moves the last
// entry to the root and a replace writes the reply there, and either then
// sifts it down, level by level. A reply that is not larger than the head
// passes straight out without touching the heap.
// Reset clears the control state and sets run_count to 1; the heap memory is
// not cleared, as only entries below the heap size are ever read.
module k_way_merge_of_sorted_runs #(
    parameter int MAX_RUNS   = kwm_pkg::DEF_MAX_RUNS,
    parameter int DATA_WIDTH = kwm_pkg::DEF_DATA_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kwm_pkg::RUN_COUNT_W-1:0] run_count,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            mode,
    input  logic [kwm_pkg::RUN_W-1:0]       run_index,
    input  logic [DATA_WIDTH-1:0]           value,
    input  logic                            has_value,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [DATA_WIDTH-1:0]           merged_value,
    output logic                            value_valid,
    output logic [kwm_pkg::RUN_W-1:0]       next_run,
    output logic                            last
);

    localparam int RUN_W   = kwm_pkg::RUN_W;
    localparam int RC_W    = kwm_pkg::RUN_COUNT_W;
    localparam int ENTRY_W = DATA_WIDTH + RUN_W;
    localparam int IDX_W   = $clog2(MAX_RUNS);
    localparam int SIZE_W  = $clog2(MAX_RUNS + 1);
    localparam int CW      = IDX_W + 2;
    localparam int EW      = (SIZE_W > RC_W) ? SIZE_W : RC_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_UP_RD   = 4'd1;
    localparam logic [3:0] ST_UP_CMP  = 4'd2;
    localparam logic [3:0] ST_EMIT    = 4'd3;
    localparam logic [3:0] ST_POP_RD  = 4'd4;
    localparam logic [3:0] ST_POP_LD  = 4'd5;
    localparam logic [3:0] ST_DN_RDL  = 4'd6;
    localparam logic [3:0] ST_DN_RDR  = 4'd7;
    localparam logic [3:0] ST_DN_CMPR = 4'd8;
    localparam logic [3:0] ST_DN_CMP  = 4'd9;
    localparam logic [3:0] ST_OUT     = 4'd10;

    logic [ENTRY_W-1:0] heap_mem [MAX_RUNS];

    logic [3:0]          state_reg, state_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [SIZE_W-1:0]   primed_reg, primed_next;
    logic [RUN_W-1:0]    pending_reg, pending_next;
    logic                finished_reg, finished_next;
    logic [RC_W-1:0]     run_count_reg, run_count_next;
    logic                emit_after_reg, emit_after_next;
    logic                result_valid_reg, result_valid_next;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [ENTRY_W-1:0]  x_reg, x_next;
    logic [ENTRY_W-1:0]  cand_reg, cand_next;
    logic [IDX_W-1:0]    cand_idx_reg, cand_idx_next;
    logic [ENTRY_W-1:0]  top_reg;
    logic [ENTRY_W-1:0]  rd_data_reg;

    logic [DATA_WIDTH-1:0] res_value_reg, res_value_next;
    logic                  res_vvalid_reg, res_vvalid_next;
    logic [RUN_W-1:0]      res_run_reg, res_run_next;
    logic                  res_last_reg, res_last_next;

    logic [DATA_WIDTH-1:0] merged_value_reg, merged_value_next;
    logic                  value_valid_reg, value_valid_next;
    logic [RUN_W-1:0]      next_run_reg, next_run_next;
    logic                  last_reg, last_next;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic [IDX_W-1:0]     rd_addr;

    logic [EW-1:0]        rc_ext;
    logic [SIZE_W-1:0]    eff_runs;
    logic                 merging;
    logic                 last_prime;
    logic                 item_accept;
    logic                 cfg_write;
    logic [DATA_WIDTH-1:0] head_value;
    logic [RUN_W-1:0]     top_run;
    logic [IDX_W-1:0]     idx_m1;
    logic [IDX_W-1:0]     parent_idx;
    logic [CW-1:0]        left_wide;
    logic [CW-1:0]        right_wide;
    logic [CW-1:0]        size_wide;

    assign rc_ext   = EW'(run_count_reg);
    assign eff_runs = (rc_ext == '0) ? SIZE_W'(1) :
                      (rc_ext > EW'(MAX_RUNS)) ? SIZE_W'(MAX_RUNS) : SIZE_W'(rc_ext);
    assign merging    = (primed_reg >= eff_runs);
    assign last_prime = ((SIZE_W + 1)'(primed_reg) + (SIZE_W + 1)'(1))
                        >= (SIZE_W + 1)'(eff_runs);

    assign item_stall  = (state_reg != ST_IDLE) | cfg_valid;
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign item_accept = item_valid & ~item_stall;
    assign cfg_write   = cfg_valid & cfg_ready;

    assign head_value = top_reg[ENTRY_W-1:RUN_W];
    assign top_run    = top_reg[RUN_W-1:0];

    assign idx_m1     = idx_reg - IDX_W'(1);
    assign parent_idx = idx_m1 >> 1;
    assign left_wide  = CW'({idx_reg, 1'b1});
    assign right_wide = left_wide + CW'(1);
    assign size_wide  = CW'(size_reg);

    always_comb
    begin
        state_next        = state_reg;
        size_next         = size_reg;
        primed_next       = primed_reg;
        pending_next      = pending_reg;
        finished_next     = finished_reg;
        run_count_next    = run_count_reg;
        emit_after_next   = emit_after_reg;
        result_valid_next = result_valid_reg & result_stall;
        idx_next          = idx_reg;
        x_next            = x_reg;
        cand_next         = cand_reg;
        cand_idx_next     = cand_idx_reg;
        res_value_next    = res_value_reg;
        res_vvalid_next   = res_vvalid_reg;
        res_run_next      = res_run_reg;
        res_last_next     = res_last_reg;
        merged_value_next = merged_value_reg;
        value_valid_next  = value_valid_reg;
        next_run_next     = next_run_reg;
        last_next         = last_reg;
        wr_en             = 1'b0;
        wr_addr           = idx_reg;
        wr_data           = x_reg;
        rd_addr           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_write)
                begin
                    run_count_next = run_count;
                    size_next      = '0;
                    primed_next    = '0;
                    pending_next   = '0;
                    finished_next  = 1'b0;
                end
                else if (item_accept && !finished_reg)
                begin
                    if (mode == kwm_pkg::MODE_PRIME)
                    begin
                        if (!merging)
                        begin
                            primed_next     = primed_reg + SIZE_W'(1);
                            emit_after_next = last_prime;
                            if (has_value)
                            begin
                                x_next     = {value, run_index};
                                idx_next   = size_reg[IDX_W-1:0];
                                size_next  = size_reg + SIZE_W'(1);
                                state_next = ST_UP_RD;
                            end
                            else if (last_prime)
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                    end
                    else if (merging)
                    begin
                        if (has_value && (size_reg == '0 || value <= head_value))
                        begin
                            res_value_next  = value;
                            res_vvalid_next = 1'b1;
                            res_run_next    = pending_reg;
                            res_last_next   = 1'b0;
                            state_next      = ST_OUT;
                        end
                        else if (has_value)
                        begin
                            res_value_next  = head_value;
                            res_vvalid_next = 1'b1;
                            res_run_next    = top_run;
                            res_last_next   = 1'b0;
                            pending_next    = top_run;
                            x_next          = {value, pending_reg};
                            idx_next        = '0;
                            state_next      = ST_DN_RDL;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end

            ST_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = emit_after_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    rd_addr    = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                wr_en = 1'b1;
                if (x_reg < rd_data_reg)
                begin
                    wr_data    = rd_data_reg;
                    idx_next   = parent_idx;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = emit_after_reg ? ST_EMIT : ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (size_reg == '0)
                begin
                    res_value_next  = '0;
                    res_vvalid_next = 1'b0;
                    res_run_next    = '0;
                    res_last_next   = 1'b1;
                    finished_next   = 1'b1;
                    state_next      = ST_OUT;
                end
                else
                begin
                    res_value_next  = head_value;
                    res_vvalid_next = 1'b1;
                    res_run_next    = top_run;
                    res_last_next   = 1'b0;
                    pending_next    = top_run;
                    size_next       = size_reg - SIZE_W'(1);
                    state_next      = (size_reg == SIZE_W'(1)) ? ST_OUT : ST_POP_RD;
                end
            end

            ST_POP_RD:
            begin
                rd_addr    = size_reg[IDX_W-1:0];
                state_next = ST_POP_LD;
            end

            ST_POP_LD:
            begin
                x_next     = rd_data_reg;
                idx_next   = '0;
                state_next = ST_DN_RDL;
            end

            ST_DN_RDL:
            begin
                if (left_wide >= size_wide)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    rd_addr    = left_wide[IDX_W-1:0];
                    state_next = ST_DN_RDR;
                end
            end

            ST_DN_RDR:
            begin
                cand_next     = rd_data_reg;
                cand_idx_next = left_wide[IDX_W-1:0];
                if (right_wide < size_wide)
                begin
                    rd_addr    = right_wide[IDX_W-1:0];
                    state_next = ST_DN_CMPR;
                end
                else
                begin
                    state_next = ST_DN_CMP;
                end
            end

            ST_DN_CMPR:
            begin
                if (rd_data_reg < cand_reg)
                begin
                    cand_next     = rd_data_reg;
                    cand_idx_next = right_wide[IDX_W-1:0];
                end
                state_next = ST_DN_CMP;
            end

            ST_DN_CMP:
            begin
                wr_en = 1'b1;
                if (cand_reg < x_reg)
                begin
                    wr_data    = cand_reg;
                    idx_next   = cand_idx_reg;
                    state_next = ST_DN_RDL;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    merged_value_next = res_value_reg;
                    value_valid_next  = res_vvalid_reg;
                    next_run_next     = res_run_reg;
                    last_next         = res_last_reg;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            size_reg         <= '0;
            primed_reg       <= '0;
            pending_reg      <= '0;
            finished_reg     <= 1'b0;
            run_count_reg    <= RC_W'(1);
            emit_after_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            size_reg         <= size_next;
            primed_reg       <= primed_next;
            pending_reg      <= pending_next;
            finished_reg     <= finished_next;
            run_count_reg    <= run_count_next;
            emit_after_reg   <= emit_after_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg          <= idx_next;
        x_reg            <= x_next;
        cand_reg         <= cand_next;
        cand_idx_reg     <= cand_idx_next;
        res_value_reg    <= res_value_next;
        res_vvalid_reg   <= res_vvalid_next;
        res_run_reg      <= res_run_next;
        res_last_reg     <= res_last_next;
        merged_value_reg <= merged_value_next;
        value_valid_reg  <= value_valid_next;
        next_run_reg     <= next_run_next;
        last_reg         <= last_next;
        if (wr_en && wr_addr == '0)
        begin
            top_reg <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= heap_mem[rd_addr];
    end

    assign result_valid = result_valid_reg;
    assign merged_value = merged_value_reg;
    assign value_valid  = value_valid_reg;
    assign next_run     = next_run_reg;
    assign last         = last_reg;

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= SIZE_W'(MAX_RUNS))
        else $error("Heap size exceeds the number of runs.");

    a_primed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg <= eff_runs)
        else $error("Priming count exceeds the configured run count.");

    a_finished_empty: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (size_reg == '0))
        else $error("Merge finished while the heap still holds entries.");

    a_last_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !value_valid)
        else $error("Last marker carries a value.");

    a_sift_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DN_RDL || state_reg == ST_DN_CMP)
            |-> (CW'(idx_reg) < size_wide))
        else $error("Sift-down position lies outside the heap.");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-way merge testbench
// Feeds priming heads and run replies into the merge, predicts every merged
// word with a heap of its own and checks the result words in order, under
// random idling on both channels and several run counts.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAXR        = kwm_pkg::DEF_MAX_RUNS;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_GOAL   = 700;

    typedef struct packed {
        bit [31:0] v;
        bit        ok;
        bit [3:0]  nr;
        bit        lst;
    } merge_out_t;

    class merge_scoreboard_t;
        bit [31:0]   heap_val [MAXR];
        bit [3:0]    heap_run [MAXR];
        int unsigned heap_len;
        int unsigned primed;
        bit [3:0]    pending;
        bit          done;
        bit [4:0]    runs_reg;
        merge_out_t  merged_due [$];
        int          errors;

        function new();
            runs_reg = 5'd1;
            errors = 0;
            clear();
        endfunction

        function void clear();
            heap_len = 0;
            primed = 0;
            pending = 4'd0;
            done = 1'b0;
        endfunction

        function void set_runs(bit [4:0] rc);
            runs_reg = rc;
            clear();
        endfunction

        function int unsigned active_runs();
            if (runs_reg == 0)
                return 1;
            if (runs_reg > MAXR)
                return MAXR;
            return 32'(runs_reg);
        endfunction

        function bit earlier(int unsigned a, int unsigned b);
            if (heap_val[a] != heap_val[b])
                return heap_val[a] < heap_val[b];
            return heap_run[a] < heap_run[b];
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            bit [31:0] tv;
            bit [3:0]  tr;
            tv = heap_val[a];
            tr = heap_run[a];
            heap_val[a] = heap_val[b];
            heap_run[a] = heap_run[b];
            heap_val[b] = tv;
            heap_run[b] = tr;
        endfunction

        function void push_head(bit [31:0] v, bit [3:0] r);
            int unsigned i;
            int unsigned p;
            if (heap_len >= MAXR)
                return;
            i = heap_len;
            heap_len++;
            heap_val[i] = v;
            heap_run[i] = r;
            while (i > 0)
            begin
                p = (i - 1) / 2;
                if (!earlier(i, p))
                    break;
                swap_slots(i, p);
                i = p;
            end
        endfunction

        function void drop_min();
            int unsigned i;
            int unsigned l;
            int unsigned m;
            i = 0;
            if (heap_len == 0)
                return;
            heap_len--;
            if (heap_len == 0)
                return;
            heap_val[0] = heap_val[heap_len];
            heap_run[0] = heap_run[heap_len];
            forever
            begin
                l = 2 * i + 1;
                if (l >= heap_len)
                    break;
                m = l;
                if (l + 1 < heap_len && earlier(l + 1, l))
                    m = l + 1;
                if (!earlier(m, i))
                    break;
                swap_slots(m, i);
                i = m;
            end
        endfunction

        function void add_word(bit [31:0] v, bit ok, bit [3:0] nr, bit lst);
            merge_out_t w;
            w.v = v;
            w.ok = ok;
            w.nr = nr;
            w.lst = lst;
            merged_due.push_back(w);
        endfunction

        function void emit_min();
            bit [31:0] v;
            if (heap_len == 0)
            begin
                done = 1'b1;
                add_word(32'd0, 1'b0, 4'd0, 1'b1);
                return;
            end
            v = heap_val[0];
            pending = heap_run[0];
            drop_min();
            add_word(v, 1'b1, pending, 1'b0);
        endfunction

        // Returns 1 when the word takes part in the merge, 0 when it is ignored.
        function bit note_word(bit m, bit [3:0] ri, bit [31:0] v, bit hv);
            int unsigned eff;
            bit          merging;
            eff = active_runs();
            merging = primed >= eff;
            if (done)
                return 1'b0;
            if (m == kwm_pkg::MODE_PRIME)
            begin
                if (merging)
                    return 1'b0;
                if (hv)
                    push_head(v, ri);
                primed++;
                if (primed >= eff)
                    emit_min();
                return 1'b1;
            end
            if (!merging)
                return 1'b0;
            if (hv)
            begin
                if (heap_len == 0 || v <= heap_val[0])
                begin
                    add_word(v, 1'b1, pending, 1'b0);
                    return 1'b1;
                end
                push_head(v, pending);
            end
            emit_min();
            return 1'b1;
        endfunction

        function void check_word(bit [31:0] v, bit ok, bit [3:0] nr, bit lst);
            merge_out_t want;
            if (merged_due.size() == 0)
            begin
                $error("result word with nothing expected: value %0h valid %0b run %0d last %0b",
                       v, ok, nr, lst);
                errors++;
                return;
            end
            want = merged_due.pop_front();
            if (want.v != v)
            begin
                $error("merged_value: expected %0h, got %0h", want.v, v);
                errors++;
            end
            if (want.ok != ok)
            begin
                $error("value_valid: expected %0b, got %0b", want.ok, ok);
                errors++;
            end
            if (want.nr != nr)
            begin
                $error("next_run: expected %0d, got %0d", want.nr, nr);
                errors++;
            end
            if (want.lst != lst)
            begin
                $error("last: expected %0b, got %0b", want.lst, lst);
                errors++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [kwm_pkg::RUN_COUNT_W-1:0] runs_cfg = 5'd1;
    logic                            item_valid = 1'b0;
    logic                            item_stall;
    logic                            mode = kwm_pkg::MODE_PRIME;
    logic [kwm_pkg::RUN_W-1:0]       run_index = '0;
    logic [31:0]                     value = '0;
    logic                            has_value = 1'b0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    logic [31:0]                     merged_value;
    logic                            value_valid;
    logic [kwm_pkg::RUN_W-1:0]       next_run;
    logic                            last;

    merge_scoreboard_t sb;
    bit                idle_on = 1'b1;
    int                stall_left = 0;
    int                useful = 0;
    int                cycle_count = 0;
    bit [31:0]         run_elems [MAXR][$];
    int                run_pos [MAXR];

    k_way_merge_of_sorted_runs uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .run_count    (runs_cfg),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .run_index    (run_index),
        .value        (value),
        .has_value    (has_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .merged_value (merged_value),
        .value_valid  (value_valid),
        .next_run     (next_run),
        .last         (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_word(merged_value, value_valid, next_run, last);
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            result_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end
        else
            result_stall <= 1'b0;
    end

    task automatic send_word(input bit m, input bit [3:0] ri, input bit [31:0] v,
                             input bit hv);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 3);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        mode <= m;
        run_index <= ri;
        value <= v;
        has_value <= hv;
        do
            @(posedge clk);
        while (item_stall);
        if (sb.note_word(m, ri, v, hv))
            useful++;
    endtask

    task automatic hold_until_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.merged_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic reconfigure(input bit [4:0] rc);
        hold_until_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        runs_cfg <= rc;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_runs(rc);
    endtask

    task automatic fill_runs(input int k, input int max_len, input int style);
        int              len;
        longint unsigned cur;
        longint unsigned step_up;
        for (int r = 0; r < MAXR; r++)
        begin
            run_elems[r].delete();
            run_pos[r] = 0;
        end
        for (int r = 0; r < k; r++)
        begin
            len = $urandom_range(0, max_len);
            case (style)
                0: cur = 64'($urandom >> $urandom_range(0, 31));
                1: cur = 64'($urandom_range(0, 6));
                default: cur = 64'(32'hFFFF_FFFF - $urandom_range(0, 12));
            endcase
            for (int i = 0; i < len; i++)
            begin
                run_elems[r].push_back(cur[31:0]);
                if (style == 0)
                    step_up = 64'($urandom >> $urandom_range(2, 31));
                else
                    step_up = 64'($urandom_range(0, 2));
                cur = cur + step_up;
                if (cur > 64'hFFFF_FFFF)
                    cur = 64'hFFFF_FFFF;
            end
        end
    endtask

    task automatic merge_episode(input bit [4:0] rc, input int max_len, input int style);
        int k;
        int r;
        int j;
        int tmp;
        int order [MAXR];
        reconfigure(rc);
        k = (rc == 0) ? 1 : ((rc > MAXR) ? MAXR : int'(rc));
        fill_runs(k, max_len, style);
        for (int i = 0; i < k; i++)
            order[i] = i;
        for (int i = k - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < k; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_word(kwm_pkg::MODE_REPLY, 4'($urandom), $urandom, 1'($urandom));
            r = order[i];
            if (run_elems[r].size() != 0)
            begin
                send_word(kwm_pkg::MODE_PRIME, 4'(r), run_elems[r][0], 1'b1);
                run_pos[r] = 1;
            end
            else
                send_word(kwm_pkg::MODE_PRIME, 4'(r), $urandom, 1'b0);
        end
        while (!sb.done)
        begin
            if ($urandom_range(0, 29) == 0)
                send_word(kwm_pkg::MODE_PRIME, 4'($urandom), $urandom, 1'($urandom));
            if ($urandom_range(0, 99) == 0)
                hold_until_drained();
            r = sb.pending;
            if (run_pos[r] < run_elems[r].size())
            begin
                send_word(kwm_pkg::MODE_REPLY, 4'($urandom), run_elems[r][run_pos[r]], 1'b1);
                run_pos[r]++;
            end
            else
                send_word(kwm_pkg::MODE_REPLY, 4'($urandom), $urandom, 1'b0);
        end
        if ($urandom_range(0, 3) == 0)
            send_word(1'($urandom), 4'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic junk_episode(input bit [4:0] rc);
        int        n;
        bit [31:0] v;
        reconfigure(rc);
        n = $urandom_range(4, 24);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: v = 32'd0;
                1: v = 32'hFFFF_FFFF;
                2: v = $urandom_range(0, 7);
                default: v = $urandom;
            endcase
            send_word(1'($urandom_range(0, 1)), 4'($urandom), v, 1'($urandom));
        end
    endtask

    task automatic random_episode();
        int        pick;
        bit [4:0]  rc;
        pick = $urandom_range(0, 9);
        if (pick <= 6)
        begin
            if ($urandom_range(0, 3) == 0)
                rc = 5'($urandom_range(1, MAXR));
            else
                rc = 5'($urandom_range(1, 4));
            merge_episode(rc, $urandom_range(0, 5), $urandom_range(0, 2));
        end
        else if (pick == 7)
            merge_episode(5'($urandom_range(0, 31)), $urandom_range(0, 2),
                          $urandom_range(0, 2));
        else
            junk_episode(5'($urandom_range(0, 31)));
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One run after reset: early reply, maximum head, equal pass-through,
        // exhaustion and a word after the last marker.
        send_word(kwm_pkg::MODE_REPLY, 4'd7, 32'd123, 1'b1);
        send_word(kwm_pkg::MODE_PRIME, 4'd0, 32'hFFFF_FFFF, 1'b1);
        send_word(kwm_pkg::MODE_REPLY, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_word(kwm_pkg::MODE_REPLY, 4'd0, 32'd0, 1'b0);
        send_word(kwm_pkg::MODE_PRIME, 4'd3, 32'd9, 1'b1);

        // A run count of zero behaves as one; an empty head ends at once.
        reconfigure(5'd0);
        send_word(kwm_pkg::MODE_PRIME, 4'd0, 32'd0, 1'b0);

        // Two runs with equal heads, an extra head during merging and replies that
        // pass straight out, one equal to the head and one into an empty heap.
        reconfigure(5'd2);
        send_word(kwm_pkg::MODE_PRIME, 4'd1, 32'd5, 1'b1);
        send_word(kwm_pkg::MODE_PRIME, 4'd0, 32'd5, 1'b1);
        send_word(kwm_pkg::MODE_REPLY, 4'd9, 32'd5, 1'b1);
        send_word(kwm_pkg::MODE_REPLY, 4'd0, 32'd6, 1'b1);
        send_word(kwm_pkg::MODE_PRIME, 4'd0, 32'd1, 1'b1);
        send_word(kwm_pkg::MODE_REPLY, 4'd1, 32'd0, 1'b0);
        send_word(kwm_pkg::MODE_REPLY, 4'd0, 32'd0, 1'b1);
        send_word(kwm_pkg::MODE_REPLY, 4'd0, 32'd0, 1'b0);

        // Repeated run number while priming and a run number above the count.
        reconfigure(5'd3);
        send_word(kwm_pkg::MODE_PRIME, 4'd2, 32'd10, 1'b1);
        send_word(kwm_pkg::MODE_PRIME, 4'd2, 32'd3, 1'b1);
        send_word(kwm_pkg::MODE_PRIME, 4'd15, 32'd0, 1'b1);
        send_word(kwm_pkg::MODE_REPLY, 4'd0, 32'd1, 1'b1);
        send_word(kwm_pkg::MODE_REPLY, 4'd0, 32'd0, 1'b0);
        send_word(kwm_pkg::MODE_REPLY, 4'd0, 32'd0, 1'b0);
        send_word(kwm_pkg::MODE_REPLY, 4'd0, 32'd0, 1'b0);

        merge_episode(5'd16, 3, 0);
        merge_episode(5'd31, 2, 2);
        merge_episode(5'd17, 2, 1);

        while (useful < ITEM_GOAL)
        begin
            if (useful > ITEM_GOAL - 120)
                idle_on = 1'b0;
            random_episode();
        end

        hold_until_drained();
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.merged_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
src/kwm_pkg.sv
src/k_way_merge_of_sorted_runs.sv
sim/testbench.sv
